@@ rtl/hci_pkg.sv @@
// ----------------------------------------------------------------------------
// hci_pkg: shared types and constants for the Hilbert curve index block
// Word widths, register indexes, quadrant codes and the per-level item.
// ----------------------------------------------------------------------------
`default_nettype none

package hci_pkg;

  localparam int unsigned IN_W         = 32;   // port coordinate width
  localparam int unsigned WORD_W       = 64;   // internal coordinate word
  localparam int unsigned PROD_W       = 128;  // full product width
  localparam int unsigned HALF_W       = 32;   // partial product split
  localparam int unsigned FRAC_EXT     = 16;   // extra fraction bits
  localparam int unsigned IDX_W        = 32;   // curve index width
  localparam int unsigned DIGIT_LEVELS = 16;   // levels that carry weight
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_AXIS_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_AXIS_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_AXIS_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_AXIS_Y = 3'd5;

  // quadrant digit codes
  typedef enum logic [1:0] {
    QUAD_SWAP   = 2'd0,
    QUAD_UP     = 2'd1,
    QUAD_ACROSS = 2'd2,
    QUAD_FLIP   = 2'd3
  } quad_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // one point in flight with its current frame and partial index
  typedef struct packed {
    word_t            px;
    word_t            py;
    word_t            ox;
    word_t            oy;
    word_t            rx;
    word_t            ry;
    word_t            bx;
    word_t            by;
    logic [IDX_W-1:0] idx;
  } item_t;

endpackage : hci_pkg

`default_nettype wire

@@ rtl/hci_mul.sv @@
// ----------------------------------------------------------------------------
// hci_mul: pipelined signed 64x64 multiplier
// Four partial products of the 32-bit halves in the first stage, 128-bit sum in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_mul import hci_pkg::*; (
  input  logic  clk,
  input  word_t a,
  input  word_t b,
  output prod_t p
);

  logic [WORD_W-1:0]        pp_ll;
  logic signed [WORD_W:0]   pp_lh;
  logic signed [WORD_W:0]   pp_hl;
  logic signed [WORD_W-1:0] pp_hh;

  // low halves unsigned, high halves signed
  always_ff @(posedge clk) begin
    pp_ll <= {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
    pp_lh <= $signed({{(HALF_W+1){1'b0}}, a[HALF_W-1:0]})
           * $signed({{(HALF_W+1){b[WORD_W-1]}}, b[WORD_W-1:HALF_W]});
    pp_hl <= $signed({{(HALF_W+1){a[WORD_W-1]}}, a[WORD_W-1:HALF_W]})
           * $signed({{(HALF_W+1){1'b0}}, b[HALF_W-1:0]});
    pp_hh <= $signed({{HALF_W{a[WORD_W-1]}}, a[WORD_W-1:HALF_W]})
           * $signed({{HALF_W{b[WORD_W-1]}}, b[WORD_W-1:HALF_W]});
  end

  always_ff @(posedge clk) begin
    p <= {pp_hh, {WORD_W{1'b0}}}
       + {{(HALF_W-1){pp_lh[WORD_W]}}, pp_lh, {HALF_W{1'b0}}}
       + {{(HALF_W-1){pp_hl[WORD_W]}}, pp_hl, {HALF_W{1'b0}}}
       + {{WORD_W{1'b0}}, pp_ll};
  end

endmodule : hci_mul

`default_nettype wire

@@ rtl/hci_cell.sv @@
// ----------------------------------------------------------------------------
// hci_cell: one level of the Hilbert descent
// Four-stage cell: offset, projections, candidate centers, quadrant pick and frame update.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_cell import hci_pkg::*; #(
  parameter int unsigned LEVEL = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output item_t out_item
);

  localparam bit          HAS_WEIGHT = (LEVEL < DIGIT_LEVELS);
  localparam int unsigned DIGIT_POS  = HAS_WEIGHT ? (IDX_W - 2 - 2 * LEVEL) : 0;

  // stage 1: offset from the frame center
  logic  s1_valid;
  item_t s1_item;
  word_t s1_dx, s1_dy;

  // stage 2: halved axes and their sum and difference
  logic  s2_valid;
  item_t s2_item;
  item_t s2_item_next;
  word_t s2_sum_x, s2_sum_y, s2_diff_x, s2_diff_y;

  // stage 3: four candidate centers
  logic  s3_valid;
  item_t s3_item;
  word_t s3_o0_x, s3_o0_y, s3_o1_x, s3_o1_y;
  word_t s3_o2_x, s3_o2_y, s3_o3_x, s3_o3_y;

  prod_t p_rx, p_ry, p_bx, p_by;
  logic signed [PROD_W:0] dot_r, dot_b;
  logic  r_pos, b_pos, b_neg;
  quad_t quad;
  item_t out_item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= in_item;
    s1_dx   <= in_item.px - in_item.ox;
    s1_dy   <= in_item.py - in_item.oy;
  end

  // projections use the axes before halving
  hci_mul u_mul_rx (.clk(clk), .a(s1_dx), .b(s1_item.rx), .p(p_rx));
  hci_mul u_mul_ry (.clk(clk), .a(s1_dy), .b(s1_item.ry), .p(p_ry));
  hci_mul u_mul_bx (.clk(clk), .a(s1_dx), .b(s1_item.bx), .p(p_bx));
  hci_mul u_mul_by (.clk(clk), .a(s1_dy), .b(s1_item.by), .p(p_by));

  // halved axes, floor toward minus infinity
  always_comb begin
    s2_item_next    = s1_item;
    s2_item_next.rx = s1_item.rx >>> 1;
    s2_item_next.ry = s1_item.ry >>> 1;
    s2_item_next.bx = s1_item.bx >>> 1;
    s2_item_next.by = s1_item.by >>> 1;
  end

  always_ff @(posedge clk) begin
    s2_item   <= s2_item_next;
    s2_sum_x  <= s2_item_next.bx + s2_item_next.rx;
    s2_sum_y  <= s2_item_next.by + s2_item_next.ry;
    s2_diff_x <= s2_item_next.bx - s2_item_next.rx;
    s2_diff_y <= s2_item_next.by - s2_item_next.ry;
  end

  always_ff @(posedge clk) begin
    s3_item <= s2_item;
    s3_o0_x <= s2_item.ox - s2_sum_x;
    s3_o0_y <= s2_item.oy - s2_sum_y;
    s3_o1_x <= s2_item.ox + s2_diff_x;
    s3_o1_y <= s2_item.oy + s2_diff_y;
    s3_o2_x <= s2_item.ox + s2_sum_x;
    s3_o2_y <= s2_item.oy + s2_sum_y;
    s3_o3_x <= s2_item.ox - s2_diff_x;
    s3_o3_y <= s2_item.oy - s2_diff_y;
  end

  // exact signs of both projections
  always_comb begin
    dot_r = {p_rx[PROD_W-1], p_rx} + {p_ry[PROD_W-1], p_ry};
    dot_b = {p_bx[PROD_W-1], p_bx} + {p_by[PROD_W-1], p_by};
    r_pos = !dot_r[PROD_W] && (dot_r != '0);
    b_pos = !dot_b[PROD_W] && (dot_b != '0);
    b_neg = dot_b[PROD_W];
  end

  // first match wins, ties fall to the lower digit
  always_comb begin
    if (!r_pos && !b_pos) begin
      quad = QUAD_SWAP;
    end else if (!r_pos) begin
      quad = QUAD_UP;
    end else if (!b_neg) begin
      quad = QUAD_ACROSS;
    end else begin
      quad = QUAD_FLIP;
    end
  end

  always_comb begin
    out_item_next = s3_item;
    case (quad)
      QUAD_SWAP: begin
        out_item_next.ox = s3_o0_x;
        out_item_next.oy = s3_o0_y;
        out_item_next.rx = s3_item.bx;
        out_item_next.ry = s3_item.by;
        out_item_next.bx = s3_item.rx;
        out_item_next.by = s3_item.ry;
      end
      QUAD_UP: begin
        out_item_next.ox = s3_o1_x;
        out_item_next.oy = s3_o1_y;
      end
      QUAD_ACROSS: begin
        out_item_next.ox = s3_o2_x;
        out_item_next.oy = s3_o2_y;
      end
      QUAD_FLIP: begin
        out_item_next.ox = s3_o3_x;
        out_item_next.oy = s3_o3_y;
        out_item_next.rx = -s3_item.bx;
        out_item_next.ry = -s3_item.by;
        out_item_next.bx = -s3_item.rx;
        out_item_next.by = -s3_item.ry;
      end
      default: begin
        out_item_next = s3_item;
      end
    endcase
    if (HAS_WEIGHT) begin
      out_item_next.idx = s3_item.idx + ({{(IDX_W-2){1'b0}}, quad} << DIGIT_POS);
    end
  end

  always_ff @(posedge clk) begin
    out_item <= out_item_next;
  end

endmodule : hci_cell

`default_nettype wire

@@ rtl/hilbert_curve_index_2d.sv @@
// ----------------------------------------------------------------------------
// hilbert_curve_index_2d: Hilbert curve index of a 2D point
// Row of level cells mapping a Q16.16 point to its position along the curve.
// ----------------------------------------------------------------------------
// Usage:
//   Frame registers (origin, red axis, blue axis; signed Q16.16) are written
//   through cfg_write / cfg_index / cfg_data while no point is in flight.
//   Index values past the last register are dropped.
//   A point transfers on a rising edge with start high and busy low. busy is
//   low whenever rst is low, so a new point may enter on every cycle.
//   Each point walks an input register and then a row of LEVELS hci_cell
//   instances, one per curve level. A cell has four stages: offset from center,
//   projection products, candidate centers, quadrant pick and frame update.
//   From the transfer a point passes the input register and then the four
//   stage registers of each cell; the last cell's output drives done.
//   Throughput: one point per cycle, in order.
//   done is high for exactly one cycle with curve_index valid; the receiver
//   cannot stall, so nothing is held back.
//   Reset clears the frame registers to zero and drops all points in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module hilbert_curve_index_2d import hci_pkg::*; #(
  parameter int unsigned LEVELS     = 16,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [IN_W-1:0]      point_x,
  input  logic [IN_W-1:0]      point_y,
  output logic                 done,
  output logic [IDX_W-1:0]     curve_index,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IN_W-1:0]      cfg_data
);

  // wrap to COORD_BITS signed, then add the extra fraction bits
  localparam int unsigned CSHIFT = WORD_W - COORD_BITS;

  logic [IN_W-1:0] origin_x, origin_y;
  logic [IN_W-1:0] red_axis_x, red_axis_y;
  logic [IN_W-1:0] blue_axis_x, blue_axis_y;

  logic  accept;
  item_t start_item;
  logic  in_valid;
  item_t in_item;

  logic  chain_valid [LEVELS+1];
  item_t chain_item  [LEVELS+1];

  function automatic word_t to_coord(input logic [IN_W-1:0] raw);
    logic [WORD_W-1:0] wide;
    wide = {{(WORD_W-IN_W){raw[IN_W-1]}}, raw} << CSHIFT;
    return ($signed(wide) >>> CSHIFT) <<< FRAC_EXT;
  endfunction

  assign busy   = rst;
  assign accept = start && !busy;

  // frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      red_axis_x  <= '0;
      red_axis_y  <= '0;
      blue_axis_x <= '0;
      blue_axis_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ORIGIN_X:    origin_x    <= cfg_data;
        CFG_ORIGIN_Y:    origin_y    <= cfg_data;
        CFG_RED_AXIS_X:  red_axis_x  <= cfg_data;
        CFG_RED_AXIS_Y:  red_axis_y  <= cfg_data;
        CFG_BLUE_AXIS_X: blue_axis_x <= cfg_data;
        CFG_BLUE_AXIS_Y: blue_axis_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    start_item.px  = to_coord(point_x);
    start_item.py  = to_coord(point_y);
    start_item.ox  = to_coord(origin_x);
    start_item.oy  = to_coord(origin_y);
    start_item.rx  = to_coord(red_axis_x);
    start_item.ry  = to_coord(red_axis_y);
    start_item.bx  = to_coord(blue_axis_x);
    start_item.by  = to_coord(blue_axis_y);
    start_item.idx = '0;
  end

  // input register: point plus a snapshot of the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_item <= start_item;
  end

  assign chain_valid[0] = in_valid;
  assign chain_item[0]  = in_item;

  // one cell per level, each hands its point to the next
  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
    hci_cell #(
      .LEVEL(lv)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[lv]),
      .in_item  (chain_item[lv]),
      .out_valid(chain_valid[lv+1]),
      .out_item (chain_item[lv+1])
    );
  end

  // last cell's registers drive the result transfer
  assign done        = chain_valid[LEVELS];
  assign curve_index = chain_item[LEVELS].idx;

endmodule : hilbert_curve_index_2d

`default_nettype wire
